@@ rtl/hgmt_pkg.sv @@
// ----------------------------------------------------------------------------
// hgmt_pkg
// Shared types, constants and the gas circuit to manifold table of the
// hierarchical gain median tracker.
// ----------------------------------------------------------------------------
package hgmt_pkg;

    localparam int NUM_TUBES        = 5248;
    localparam int TUBES_PER_MODULE = 16;
    localparam int NUM_MODULES      = 328;
    localparam int NUM_HV_GROUPS    = 82;
    localparam int NUM_MANIFOLDS    = 10;
    localparam int NUM_CIRCUITS     = 41;

    localparam int TID_W = $clog2(NUM_TUBES);
    localparam int MOD_W = $clog2(NUM_MODULES);
    localparam int HV_W  = $clog2(NUM_HV_GROUPS);
    localparam int MF_W  = $clog2(NUM_MANIFOLDS);

    localparam int AMP_W  = 12;
    localparam int DET_W  = 22;
    localparam int LVL_W  = 16;
    localparam int CNT_W  = 24;
    // Product of the detector and three relative levels.
    localparam int PROD_W = DET_W + 3 * LVL_W;
    // Product of all five levels, also wide enough for amplitude << 62.
    localparam int ACC_W  = PROD_W + LVL_W;
    // Multiplicand chunk handled per multiplier cycle.
    localparam int CHUNK_W = 24;
    localparam int NUM_CHUNKS = (PROD_W + CHUNK_W - 1) / CHUNK_W;

    localparam logic [LVL_W-1:0] LEVEL_ONE = LVL_W'(8192);
    localparam logic [LVL_W-1:0] LEVEL_MAX = '1;
    localparam logic [DET_W-1:0] DET_MAX   = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Configuration register indexes.
    localparam logic CFG_AMP_THRESHOLD = 1'b0;
    localparam logic CFG_PEAK_AMP      = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_RD,
        S_START,
        S_MUL,
        S_CMP,
        S_DONE
    } t_state;

    // Hierarchy level being updated.
    typedef enum logic [1:0] {
        L_MANIFOLD,
        L_HV,
        L_MODULE,
        L_TUBE
    } t_level;

    typedef struct packed {
        logic             ok;
        logic [TID_W-1:0] tid;
        logic [MOD_W-1:0] module_idx;
        logic [HV_W-1:0]  hv;
        logic [MF_W-1:0]  mf;
    } t_map;

    // Manifold of each gas circuit.
    function automatic logic [3:0] circuit_manifold(input logic [5:0] gc);
        logic [3:0] m;
        unique case (gc)
            6'd0:  m = 4'd9;  6'd1:  m = 4'd8;  6'd2:  m = 4'd5;  6'd3:  m = 4'd2;
            6'd4:  m = 4'd4;  6'd5:  m = 4'd1;  6'd6:  m = 4'd3;  6'd7:  m = 4'd3;
            6'd8:  m = 4'd7;  6'd9:  m = 4'd2;  6'd10: m = 4'd5;  6'd11: m = 4'd1;
            6'd12: m = 4'd6;  6'd13: m = 4'd0;  6'd14: m = 4'd8;  6'd15: m = 4'd0;
            6'd16: m = 4'd6;  6'd17: m = 4'd1;  6'd18: m = 4'd9;  6'd19: m = 4'd2;
            6'd20: m = 4'd8;  6'd21: m = 4'd4;  6'd22: m = 4'd7;  6'd23: m = 4'd6;
            6'd24: m = 4'd4;  6'd25: m = 4'd5;  6'd26: m = 4'd3;  6'd27: m = 4'd7;
            6'd28: m = 4'd0;  6'd29: m = 4'd5;  6'd30: m = 4'd2;  6'd31: m = 4'd9;
            6'd32: m = 4'd7;  6'd33: m = 4'd7;  6'd34: m = 4'd9;  6'd35: m = 4'd6;
            6'd36: m = 4'd8;  6'd37: m = 4'd3;  6'd38: m = 4'd0;  6'd39: m = 4'd4;
            6'd40: m = 4'd1;
            default: m = 4'd0;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/hgmt_ram.sv @@
// ----------------------------------------------------------------------------
// hgmt_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module hgmt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port on one address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/hgmt_map.sv @@
// ----------------------------------------------------------------------------
// hgmt_map
// Maps a hit position to tube, module, HV group and manifold indexes and
// flags positions outside the detector.
// ----------------------------------------------------------------------------
module hgmt_map (
    input  logic [4:0]      i_layer,
    input  logic [4:0]      i_ladder,
    input  logic [3:0]      i_tube,
    output hgmt_pkg::t_map  o_map
);
    import hgmt_pkg::*;

    logic [6:0]  w_ladder;
    logic [12:0] w_full;
    logic [5:0]  w_gc;
    logic [3:0]  w_mf;

    // Ladder offset per layer group, then the linear tube index.
    always_comb begin
        w_ladder = {2'b00, i_ladder};
        if (i_layer > 5'd3)  w_ladder = w_ladder + 7'd14;
        if (i_layer > 5'd7)  w_ladder = w_ladder + 7'd16;
        if (i_layer > 5'd11) w_ladder = w_ladder + 7'd16;
        if (i_layer > 5'd15) w_ladder = w_ladder + 7'd18;
        w_full = {w_ladder, i_layer[1:0], i_tube};
        w_gc   = w_full[12:7];
        w_mf   = circuit_manifold(w_gc);
    end

    // Range checks on every level of the hierarchy.
    always_comb begin
        o_map.ok = (14'(w_full) < 14'(NUM_TUBES))
                && (10'(w_full[12:4]) < 10'(NUM_MODULES))
                && (8'(w_full[12:6]) < 8'(NUM_HV_GROUPS))
                && (7'(w_gc) < 7'(NUM_CIRCUITS))
                && (5'(w_mf) < 5'(NUM_MANIFOLDS));
        o_map.tid        = w_full[TID_W-1:0];
        o_map.module_idx = w_full[4 +: MOD_W];
        o_map.hv         = w_full[6 +: HV_W];
        o_map.mf         = w_mf[MF_W-1:0];
    end

endmodule

@@ rtl/hgmt_mul.sv @@
// ----------------------------------------------------------------------------
// hgmt_mul
// Multi-cycle multiplier: wide product times a 16-bit level, one 24-bit
// chunk of the multiplicand per cycle.
// ----------------------------------------------------------------------------
module hgmt_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hgmt_pkg::PROD_W-1:0] i_mcand,
    input  logic [hgmt_pkg::LVL_W-1:0]  i_mplier,
    output logic                       o_done,
    output logic [hgmt_pkg::ACC_W-1:0]  o_product
);
    import hgmt_pkg::*;

    localparam int CW = $clog2(NUM_CHUNKS + 1);

    logic [CHUNK_W*NUM_CHUNKS-1:0] w_ext;
    logic [CHUNK_W-1:0]            w_chunk;
    logic [ACC_W-1:0]              w_part;
    logic [ACC_W-1:0]              r_acc;
    logic [CW-1:0]                 r_cnt;
    logic                          r_busy;
    logic                          r_done;

    // Partial product of the current chunk, aligned to its weight.
    always_comb begin
        w_ext   = (CHUNK_W*NUM_CHUNKS)'(i_mcand);
        w_chunk = w_ext[r_cnt*CHUNK_W +: CHUNK_W];
        w_part  = ACC_W'(w_chunk * i_mplier) << (r_cnt * CHUNK_W);
    end

    // Control of the chunk sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NUM_CHUNKS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Accumulator.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_part;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

@@ rtl/hierarchical_gain_median_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// hierarchical_gain_median_tracker_unit
// Tracks running gain medians over detector, manifold, HV group, module and
// tube, plus a saturating hit count per tube.
// ----------------------------------------------------------------------------
// Usage:
// Hits enter on the input channel (i_in_valid / o_in_stall); one result per
// accepted hit that passes the threshold and range checks leaves on the
// output channel (o_out_valid / i_out_stall). A restart item reloads the
// detector median from the expected peak amplitude register and gives no
// result. The user must write registers through i_cfg_we / i_cfg_index /
// i_cfg_data only while the block idles; the block does not enforce this.
// A restart or a hit below threshold leaves the block idle, a hit outside the
// detector returns to idle after mapping. A valid hit passes mapping and a
// memory read, then per level one multiplier start, the chunk steps of the
// shared 24x16 multiplier, its done flag and a compare, then the count write.
// No new item is taken while a hit is in work; the next item is taken the
// cycle after the result is registered.
// After reset the block sweeps all memories to their initial values,
// holding o_in_stall high. A stalled receiver holds the result register; the
// block still takes items and works one further hit with a result, which
// waits in its last step until the register is free.
// ----------------------------------------------------------------------------
module hierarchical_gain_median_tracker_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [11:0]                 i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [4:0]                  i_layer,
    input  logic [4:0]                  i_ladder,
    input  logic [3:0]                  i_tube,
    input  logic [11:0]                 i_amplitude,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [12:0]                 o_tube_index,
    output logic [21:0]                 o_detector_median,
    output logic [15:0]                 o_tube_median,
    output logic [23:0]                 o_occupancy
);
    import hgmt_pkg::*;

    t_state           r_state, n_state;
    t_level           r_lvl;
    t_map             w_map;

    logic [AMP_W-1:0] r_thr, r_start;
    logic [AMP_W-1:0] r_amp;
    logic [4:0]       r_layer, r_ladder;
    logic [3:0]       r_tube;
    logic [TID_W-1:0] r_tid;
    logic [MOD_W-1:0] r_mod;
    logic [HV_W-1:0]  r_hv;
    logic [MF_W-1:0]  r_mf;
    logic [DET_W-1:0] r_det;
    logic [PROD_W-1:0] r_p;
    logic [LVL_W-1:0] r_tube_new;
    logic             r_clearing;
    logic [TID_W-1:0] r_clr_addr;

    logic             r_out_valid;
    logic [TID_W-1:0] r_out_tid;
    logic [DET_W-1:0] r_out_det;
    logic [LVL_W-1:0] r_out_tube;
    logic [CNT_W-1:0] r_out_cnt;

    logic             w_accept, w_out_free;
    logic             w_mul_start, w_mul_done;
    logic [ACC_W-1:0] w_prod, w_lhs;
    logic [LVL_W-1:0] w_lvl_old, w_lvl_new;
    logic             w_up, w_dn;
    logic [CNT_W-1:0] w_cnt_new;
    logic [23:0]      w_restart;
    logic [DET_W-1:0] w_det_hit;

    logic [LVL_W-1:0] w_mf_rd, w_hv_rd, w_mod_rd, w_tube_rd;
    logic [CNT_W-1:0] w_cnt_rd;
    logic             w_mf_we, w_hv_we, w_mod_we, w_tube_we, w_cnt_we;
    logic [MF_W-1:0]  w_mf_addr;
    logic [HV_W-1:0]  w_hv_addr;
    logic [MOD_W-1:0] w_mod_addr;
    logic [TID_W-1:0] w_tid_addr;
    logic [LVL_W-1:0] w_lvl_wdata;
    logic [CNT_W-1:0] w_cnt_wdata;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    hgmt_map u_map (
        .i_layer  (r_layer),
        .i_ladder (r_ladder),
        .i_tube   (r_tube),
        .o_map    (w_map)
    );

    hgmt_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (r_p),
        .i_mplier  (w_lvl_old),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    // Memory addressing: clearing sweep after reset, else the current hit.
    always_comb begin
        w_mf_addr   = r_clearing ? r_clr_addr[MF_W-1:0]  : r_mf;
        w_hv_addr   = r_clearing ? r_clr_addr[HV_W-1:0]  : r_hv;
        w_mod_addr  = r_clearing ? r_clr_addr[MOD_W-1:0] : r_mod;
        w_tid_addr  = r_clearing ? r_clr_addr            : r_tid;
        w_lvl_wdata = r_clearing ? LEVEL_ONE : w_lvl_new;
        w_cnt_wdata = r_clearing ? '0 : w_cnt_new;
    end

    hgmt_ram #(.DEPTH(NUM_MANIFOLDS), .WIDTH(LVL_W)) u_mf_ram (
        .i_clk(i_clk), .i_we(w_mf_we), .i_addr(w_mf_addr),
        .i_wdata(w_lvl_wdata), .o_rdata(w_mf_rd)
    );
    hgmt_ram #(.DEPTH(NUM_HV_GROUPS), .WIDTH(LVL_W)) u_hv_ram (
        .i_clk(i_clk), .i_we(w_hv_we), .i_addr(w_hv_addr),
        .i_wdata(w_lvl_wdata), .o_rdata(w_hv_rd)
    );
    hgmt_ram #(.DEPTH(NUM_MODULES), .WIDTH(LVL_W)) u_mod_ram (
        .i_clk(i_clk), .i_we(w_mod_we), .i_addr(w_mod_addr),
        .i_wdata(w_lvl_wdata), .o_rdata(w_mod_rd)
    );
    hgmt_ram #(.DEPTH(NUM_TUBES), .WIDTH(LVL_W)) u_tube_ram (
        .i_clk(i_clk), .i_we(w_tube_we), .i_addr(w_tid_addr),
        .i_wdata(w_lvl_wdata), .o_rdata(w_tube_rd)
    );
    hgmt_ram #(.DEPTH(NUM_TUBES), .WIDTH(CNT_W)) u_cnt_ram (
        .i_clk(i_clk), .i_we(w_cnt_we), .i_addr(w_tid_addr),
        .i_wdata(w_cnt_wdata), .o_rdata(w_cnt_rd)
    );

    // Level arithmetic: select, compare with the scaled amplitude, nudge; tube count and restart value.
    always_comb begin
        unique case (r_lvl)
            L_MANIFOLD: begin
                w_lvl_old = w_mf_rd;
                w_lhs     = ACC_W'(r_amp) << 23;
            end
            L_HV: begin
                w_lvl_old = w_hv_rd;
                w_lhs     = ACC_W'(r_amp) << 36;
            end
            L_MODULE: begin
                w_lvl_old = w_mod_rd;
                w_lhs     = ACC_W'(r_amp) << 49;
            end
            L_TUBE: begin
                w_lvl_old = w_tube_rd;
                w_lhs     = ACC_W'(r_amp) << 62;
            end
            default: begin
                w_lvl_old = w_mf_rd;
                w_lhs     = '0;
            end
        endcase
        w_up = (w_lhs > w_prod) && (w_lvl_old != LEVEL_MAX);
        w_dn = (w_lhs < w_prod) && (w_lvl_old != '0);
        w_lvl_new = w_up ? w_lvl_old + LVL_W'(1)
                  : (w_dn ? w_lvl_old - LVL_W'(1) : w_lvl_old);
        w_cnt_new = (w_cnt_rd == COUNT_MAX) ? w_cnt_rd : w_cnt_rd + CNT_W'(1);
        w_restart = 24'(r_start) * 24'd2560;
        w_det_hit = r_det;
        if ((DET_W'(r_amp) << 10) > r_det && r_det != DET_MAX) begin
            w_det_hit = r_det + DET_W'(1);
        end else if ((DET_W'(r_amp) << 10) < r_det && r_det != '0) begin
            w_det_hit = r_det - DET_W'(1);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && !i_action && i_amplitude >= r_thr) n_state = S_MAP;
            end
            S_MAP:   n_state = w_map.ok ? S_RD : S_IDLE;
            S_RD:    n_state = S_START;
            S_START: n_state = S_MUL;
            S_MUL:   if (w_mul_done) n_state = S_CMP;
            S_CMP:   n_state = (r_lvl == L_TUBE) ? S_DONE : S_START;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: input stall, multiplier start, memory writes.
    always_comb begin
        o_in_stall  = r_clearing || (r_state != S_IDLE);
        w_mul_start = (r_state == S_START);
        w_mf_we   = r_clearing ? (r_clr_addr < TID_W'(NUM_MANIFOLDS))
                               : (r_state == S_CMP && r_lvl == L_MANIFOLD);
        w_hv_we   = r_clearing ? (r_clr_addr < TID_W'(NUM_HV_GROUPS))
                               : (r_state == S_CMP && r_lvl == L_HV);
        w_mod_we  = r_clearing ? (r_clr_addr < TID_W'(NUM_MODULES))
                               : (r_state == S_CMP && r_lvl == L_MODULE);
        w_tube_we = r_clearing || (r_state == S_CMP && r_lvl == L_TUBE);
        w_cnt_we  = r_clearing || (r_state == S_DONE && w_out_free);
    end

    // Control registers: state, clearing sweep, configuration, detector level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_thr      <= AMP_W'(5);
            r_start    <= '0;
            r_det      <= '0;
            r_lvl      <= L_MANIFOLD;
        end else begin
            r_state <= n_state;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + TID_W'(1);
                if (r_clr_addr == TID_W'(NUM_TUBES - 1)) r_clearing <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_AMP_THRESHOLD: r_thr   <= i_cfg_data;
                    CFG_PEAK_AMP:      r_start <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept && i_action) begin
                r_det <= (w_restart > 24'(DET_MAX)) ? DET_MAX : w_restart[DET_W-1:0];
            end
            if (r_state == S_MAP && w_map.ok) begin
                r_det <= w_det_hit;
                r_lvl <= L_MANIFOLD;
            end
            if (r_state == S_CMP) begin
                unique case (r_lvl)
                    L_MANIFOLD: r_lvl <= L_HV;
                    L_HV:       r_lvl <= L_MODULE;
                    L_MODULE:   r_lvl <= L_TUBE;
                    L_TUBE:     r_lvl <= L_TUBE;
                    default:    r_lvl <= L_MANIFOLD;
                endcase
            end
        end
    end

    // Item payload, mapped indexes and the running product.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_amp    <= i_amplitude;
            r_layer  <= i_layer;
            r_ladder <= i_ladder;
            r_tube   <= i_tube;
        end
        if (r_state == S_MAP) begin
            r_tid <= w_map.tid;
            r_mod <= w_map.module_idx;
            r_hv  <= w_map.hv;
            r_mf  <= w_map.mf;
            r_p   <= PROD_W'(w_det_hit);
        end
        // The product with the nudged level is the old product plus or minus r_p.
        if (r_state == S_CMP) begin
            if (w_up) r_p <= PROD_W'(w_prod + ACC_W'(r_p));
            else if (w_dn) r_p <= PROD_W'(w_prod - ACC_W'(r_p));
            else r_p <= PROD_W'(w_prod);
            if (r_lvl == L_TUBE) r_tube_new <= w_lvl_new;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_tid  <= r_tid;
            r_out_det  <= r_det;
            r_out_tube <= r_tube_new;
            r_out_cnt  <= w_cnt_new;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_tube_index      = r_out_tid;
    assign o_detector_median = r_out_det;
    assign o_tube_median     = r_out_tube;
    assign o_occupancy       = r_out_cnt;

    // The multiplier finishes only while the sequencer waits for it.
    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> r_state == S_MUL)
        else $error("multiplier finished outside its wait state");

    // At most one level memory is written per cycle outside the sweep.
    a_one_level_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clearing |-> $onehot0({w_mf_we, w_hv_we, w_mod_we, w_tube_we}))
        else $error("two level memories written in one cycle");

    // A new result appears only from the final step of a hit.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result loaded outside the final step");

    // No item is taken during the clearing sweep.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !w_accept && r_state == S_IDLE)
        else $error("item taken during the memory sweep");

endmodule

@@ verif/hierarchical_gain_median_tracker_unit_tb.sv @@
// ----------------------------------------------------------------------------
// hierarchical_gain_median_tracker_unit_tb
// Self-checking bench for the gain median tracker. Hits and restarts are sent
// with random gaps and the output is stalled at random. An in-bench model of
// the five median levels and the tube counts predicts each result. Every
// result is compared field by field, in order.
// ----------------------------------------------------------------------------
module hierarchical_gain_median_tracker_unit_tb;
    import hgmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_HIT     = 1'b0;
    localparam logic ACT_RESTART = 1'b1;
    localparam int   LIMIT_CYCLES = 1_000_000;
    localparam int   DRAIN_CYCLES = 40;
    localparam int   GC_MANIFOLD [NUM_CIRCUITS] = '{
        9, 8, 5, 2, 4, 1, 3, 3, 7, 2,
        5, 1, 6, 0, 8, 0, 6, 1, 9, 2,
        8, 4, 7, 6, 4, 5, 3, 7, 0, 5,
        2, 9, 7, 7, 9, 6, 8, 3, 0, 4,
        1
    };

    typedef struct {
        logic [12:0] tube_index;
        logic [21:0] detector_median;
        logic [15:0] tube_median;
        logic [23:0] occupancy;
    } t_tube_update;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [11:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_action;
    logic [4:0]  i_layer;
    logic [4:0]  i_ladder;
    logic [3:0]  i_tube;
    logic [11:0] i_amplitude;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [12:0] o_tube_index;
    logic [21:0] o_detector_median;
    logic [15:0] o_tube_median;
    logic [23:0] o_occupancy;

    // Shadow state of the tracker.
    logic [11:0] thr_q;
    logic [11:0] start_q;
    logic [21:0] det_q;
    logic [15:0] mf_lvl [NUM_MANIFOLDS];
    logic [15:0] hv_lvl [NUM_HV_GROUPS];
    logic [15:0] mod_lvl [NUM_MODULES];
    logic [15:0] tube_lvl [NUM_TUBES];
    logic [23:0] tube_cnt [NUM_TUBES];

    t_tube_update pending_updates[$];
    int           error_count;
    int           cycle_count;
    int           hold_left;
    bit           tx_quiet;
    bit           rx_quiet;
    int           hot_tubes [8];

    hierarchical_gain_median_tracker_unit u_dut (.*);

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR at cycle %0d: %s", cycle_count, what);
    endtask

    // Random gap length: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [15:0] nudge_level(input logic [15:0] lvl,
                                                input logic [127:0] a,
                                                input logic [127:0] b);
        if (a > b && lvl != LEVEL_MAX) return lvl + 16'd1;
        if (a < b && lvl != 16'd0) return lvl - 16'd1;
        return lvl;
    endfunction

    function automatic void clear_model();
        thr_q = 12'd5;
        start_q = 12'd0;
        det_q = '0;
        foreach (mf_lvl[i]) mf_lvl[i] = LEVEL_ONE;
        foreach (hv_lvl[i]) hv_lvl[i] = LEVEL_ONE;
        foreach (mod_lvl[i]) mod_lvl[i] = LEVEL_ONE;
        foreach (tube_lvl[i]) begin
            tube_lvl[i] = LEVEL_ONE;
            tube_cnt[i] = '0;
        end
    endfunction

    // Applies one accepted item to the shadow state and queues its result.
    function automatic void track_item(input logic act, input logic [4:0] layer,
                                       input logic [4:0] ladder, input logic [3:0] tube,
                                       input logic [11:0] amp);
        int unsigned  lad, tid, mdl, hv, gc, mf, prod;
        logic [127:0] lhs, rhs;
        t_tube_update upd;
        if (act == ACT_RESTART) begin
            prod = start_q * 2560;
            det_q = (prod > DET_MAX) ? DET_MAX : prod[21:0];
            return;
        end
        if (amp < thr_q) return;
        lad = ladder;
        if (layer > 3) lad += 14;
        if (layer > 7) lad += 16;
        if (layer > 11) lad += 16;
        if (layer > 15) lad += 18;
        tid = (lad * 4 + layer % 4) * 16 + tube;
        if (tid >= NUM_TUBES) return;
        mdl = tid / TUBES_PER_MODULE;
        if (mdl >= NUM_MODULES) return;
        hv = mdl / 4;
        if (hv >= NUM_HV_GROUPS) return;
        gc = hv / 2;
        if (gc >= NUM_CIRCUITS) return;
        mf = GC_MANIFOLD[gc];
        if (mf >= NUM_MANIFOLDS) return;

        // Detector level against the plain amplitude.
        lhs = {116'd0, amp} << 10;
        if (lhs > det_q && det_q != DET_MAX) det_q = det_q + 22'd1;
        else if (lhs < det_q && det_q != 0) det_q = det_q - 22'd1;

        // Each relative level sees the levels above it as already updated.
        rhs = det_q;
        lhs = lhs << 13;
        mf_lvl[mf] = nudge_level(mf_lvl[mf], lhs, rhs * mf_lvl[mf]);
        rhs = rhs * mf_lvl[mf];
        lhs = lhs << 13;
        hv_lvl[hv] = nudge_level(hv_lvl[hv], lhs, rhs * hv_lvl[hv]);
        rhs = rhs * hv_lvl[hv];
        lhs = lhs << 13;
        mod_lvl[mdl] = nudge_level(mod_lvl[mdl], lhs, rhs * mod_lvl[mdl]);
        rhs = rhs * mod_lvl[mdl];
        lhs = lhs << 13;
        tube_lvl[tid] = nudge_level(tube_lvl[tid], lhs, rhs * tube_lvl[tid]);
        if (tube_cnt[tid] != COUNT_MAX) tube_cnt[tid] = tube_cnt[tid] + 24'd1;

        upd.tube_index = tid[12:0];
        upd.detector_median = det_q;
        upd.tube_median = tube_lvl[tid];
        upd.occupancy = tube_cnt[tid];
        pending_updates.push_back(upd);
    endfunction

    // Sends one item and waits for its transfer.
    task automatic send_item(input logic act, input logic [4:0] layer,
                             input logic [4:0] ladder, input logic [3:0] tube,
                             input logic [11:0] amp);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_layer <= layer;
        i_ladder <= ladder;
        i_tube <= tube;
        i_amplitude <= amp;
        do @(posedge i_clk); while (o_in_stall);
        track_item(act, layer, ladder, tube, amp);
    endtask

    task automatic send_hit(input int tid, input logic [11:0] amp);
        int lad, layer;
        lad = tid / 64;
        layer = (tid / 16) % 4;
        // Pick the layer group that folds the ladder back to its field range.
        if (lad >= 64) begin layer += 16; lad -= 64; end
        else if (lad >= 46) begin layer += 12; lad -= 46; end
        else if (lad >= 30) begin layer += 8; lad -= 30; end
        else if (lad >= 18) begin layer += 4; lad -= 14; end
        send_item(ACT_HIT, layer[4:0], lad[4:0], tid[3:0], amp);
    endtask

    // Waits until every queued result is back, plus a tail for silent items.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [11:0] thr, input logic [11:0] start);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_AMP_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_index <= CFG_PEAK_AMP;
        i_cfg_data <= start;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        thr_q = thr;
        start_q = start;
    endtask

    // Output stall generator with an optional long hold.
    int stall_run;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (rx_quiet) begin
            i_out_stall <= 1'b0;
        end else if (stall_run > 0) begin
            stall_run--;
        end else begin
            i_out_stall <= ($urandom_range(99) < 30);
            stall_run = pick_gap();
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_tube_update exp_upd;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_updates.size() == 0) begin
                report_mismatch("result with no expected update");
            end else begin
                exp_upd = pending_updates.pop_front();
                if (o_tube_index !== exp_upd.tube_index)
                    report_mismatch($sformatf("tube_index %0d, expected %0d",
                                              o_tube_index, exp_upd.tube_index));
                if (o_detector_median !== exp_upd.detector_median)
                    report_mismatch($sformatf("detector_median %0d, expected %0d",
                                              o_detector_median, exp_upd.detector_median));
                if (o_tube_median !== exp_upd.tube_median)
                    report_mismatch($sformatf("tube_median %0d, expected %0d",
                                              o_tube_median, exp_upd.tube_median));
                if (o_occupancy !== exp_upd.occupancy)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              o_occupancy, exp_upd.occupancy));
            end
        end
    end

    // Field extremes, layer boundaries, restart and threshold edges.
    task automatic test_directed();
        configure(12'd0, 12'd4095);
        send_item(ACT_RESTART, 5'd0, 5'd0, 4'd0, 12'd0);
        send_item(ACT_HIT, 5'd0, 5'd0, 4'd0, 12'd4095);
        send_item(ACT_HIT, 5'd19, 5'd17, 4'd15, 12'd0);
        send_item(ACT_HIT, 5'd3, 5'd17, 4'd15, 12'd100);
        send_item(ACT_HIT, 5'd4, 5'd0, 4'd0, 12'd4095);
        send_item(ACT_HIT, 5'd7, 5'd17, 4'd7, 12'd2048);
        send_item(ACT_HIT, 5'd8, 5'd0, 4'd8, 12'd1);
        send_item(ACT_HIT, 5'd11, 5'd15, 4'd3, 12'd4000);
        send_item(ACT_HIT, 5'd12, 5'd0, 4'd0, 12'd2);
        send_item(ACT_HIT, 5'd15, 5'd17, 4'd15, 12'd3000);
        send_item(ACT_HIT, 5'd16, 5'd0, 4'd1, 12'd500);
        // The first two positions lie outside the detector and are dropped; the third maps inside it.
        send_item(ACT_HIT, 5'd31, 5'd31, 4'd15, 12'd4095);
        send_item(ACT_HIT, 5'd19, 5'd18, 4'd0, 12'd4095);
        send_item(ACT_HIT, 5'd2, 5'd31, 4'd10, 12'd4095);
        // Zero detector median, amplitude zero gives equal sides.
        configure(12'd0, 12'd0);
        send_item(ACT_RESTART, 5'd0, 5'd0, 4'd0, 12'd0);
        send_item(ACT_HIT, 5'd1, 5'd1, 4'd1, 12'd0);
        send_item(ACT_HIT, 5'd1, 5'd1, 4'd1, 12'd4095);
        // Threshold at its top: only the maximum amplitude passes.
        configure(12'd4095, 12'd1);
        send_item(ACT_HIT, 5'd5, 5'd5, 4'd5, 12'd4094);
        send_item(ACT_HIT, 5'd5, 5'd5, 4'd5, 12'd4095);
        send_item(ACT_RESTART, 5'd0, 5'd0, 4'd0, 12'd0);
        send_item(ACT_HIT, 5'd5, 5'd5, 4'd5, 12'd4095);
    endtask

    // One random item: mostly hits near the expected peak on a few tubes.
    task automatic send_random_item(input logic [11:0] peak);
        int r, tid, amp;
        r = $urandom_range(99);
        if (r < 4) begin
            send_item(ACT_RESTART, 5'($urandom), 5'($urandom), 4'($urandom), 12'($urandom));
        end else if (r < 10) begin
            send_item(ACT_HIT, 5'($urandom), 5'($urandom), 4'($urandom), 12'($urandom));
        end else begin
            tid = (r < 70) ? hot_tubes[$urandom_range(7)] : $urandom_range(NUM_TUBES - 1);
            amp = (r % 5 == 0) ? $urandom_range(4095)
                               : int'(peak) + $urandom_range(200) - 100;
            if (amp < 0) amp = 0;
            if (amp > 4095) amp = 4095;
            send_hit(tid, 12'(amp));
        end
    endtask

    task automatic test_random_phases();
        logic [11:0] peak;
        for (int ph = 0; ph < 6; ph++) begin
            peak = (ph == 0) ? 12'd4095 : (ph == 1) ? 12'd0 : 12'($urandom_range(4095));
            tx_quiet = (ph == 2);
            rx_quiet = (ph == 2);
            configure(12'($urandom_range(64)), peak);
            send_item(ACT_RESTART, 5'd0, 5'd0, 4'd0, 12'd0);
            for (int n = 0; n < 200; n++) send_random_item(peak);
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Long receiver hold while the sender keeps offering back to back.
    task automatic test_backpressure();
        configure(12'd5, 12'd800);
        send_item(ACT_RESTART, 5'd0, 5'd0, 4'd0, 12'd0);
        tx_quiet = 1'b1;
        hold_left = 400;
        for (int n = 0; n < 20; n++) send_random_item(12'd800);
        tx_quiet = 1'b0;
    endtask

    // Threshold high enough that many hits drop out.
    task automatic test_threshold_filter();
        configure(12'($urandom_range(3000, 1500)), 12'd1600);
        send_item(ACT_RESTART, 5'd0, 5'd0, 4'd0, 12'd0);
        for (int n = 0; n < 200; n++) send_random_item(12'd1600);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_AMP_THRESHOLD;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_action <= ACT_HIT;
        i_layer <= '0;
        i_ladder <= '0;
        i_tube <= '0;
        i_amplitude <= '0;
        i_out_stall <= 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_left = 0;
        stall_run = 0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        foreach (hot_tubes[i]) hot_tubes[i] = $urandom_range(NUM_TUBES - 1);
        hot_tubes[0] = 0;
        hot_tubes[1] = NUM_TUBES - 1;
        clear_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phases();
        test_backpressure();
        test_threshold_filter();
        drain();

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/hgmt_pkg.sv
rtl/hgmt_ram.sv
rtl/hgmt_map.sv
rtl/hgmt_mul.sv
rtl/hierarchical_gain_median_tracker_unit.sv
verif/hierarchical_gain_median_tracker_unit_tb.sv
